### design/cssd_pkg.sv
`default_nettype none
package cssd_pkg;

  localparam int VALUE_W  = 16;  // candidate value width
  localparam int SUM_W    = 10;  // table entry / target width
  localparam int IN_PAD   = 0;   // input tdata fill bits
  localparam int OUT_PAD  = 6;   // output tdata fill bits
  localparam int TUSER_W  = 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL,
    ST_GAP,
    ST_BT_RD,
    ST_BT_EV
  } cssd_state_t;

  // insert request into the sorted store
  typedef struct packed {
    logic               en;
    logic [VALUE_W-1:0] value;
  } cssd_ins_t;

  // one result transaction
  typedef struct packed {
    logic [VALUE_W-1:0] element;
    logic [SUM_W-1:0]   best_sum;
    logic               empty_res;
    logic               overflow;
    logic               final_res;
  } cssd_res_t;

endpackage
`default_nettype wire

### design/closest_subset_sum_dp_unit.sv
`default_nettype none
// Closest subset sum unit. Values stream in on s_axis, one transaction per
// cycle, and are kept sorted ascending in a row of cells (up to MAX_ITEMS;
// later values are dropped and flagged as overflow). The transaction with
// tlast set starts the run: the 0/1 subset-sum table is filled in a single
// synchronous RAM, one entry per cycle, rows 1..n by columns 0..t with
// t = min(target, MAX_TARGET), and an idle gap state between rows so a row
// is fully written before it is read. The walk back then reads and then
// evaluates each row it visits, and emits the chosen values on m_axis,
// largest index first, each carrying the best sum; an empty subset gives
// a single result with empty_res set. s_axis_tready is low from the last
// value until the final result is handed to the output register. Row 0 is
// implied zero and is never stored, so no clearing pass is needed after
// reset. target must be written via cfg_we/cfg_wdata only while the unit
// is idle; the unit does not enforce this. target is kept across runs.
module closest_subset_sum_dp_unit
  import cssd_pkg::*;
#(
  parameter int MAX_ITEMS  = 32,
  parameter int MAX_TARGET = 1023
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_wdata,     // target
  // value stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] value
  input  wire logic        s_axis_tlast,  // last
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [15:0] element, [25:16] best_sum, rest zero
  output logic [1:0]       m_axis_tuser,  // [0] empty_res, [1] overflow
  output logic             m_axis_tlast   // final_res
);

  localparam int COLS = ((MAX_TARGET < 1023) ? MAX_TARGET : 1023) + 1;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int RW   = $clog2(MAX_ITEMS + 1);
  localparam int IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int AW   = RW + CW;
  localparam int DEPTH = (MAX_ITEMS + 1) * (2 ** CW);

  cssd_state_t state, state_next;

  logic [SUM_W-1:0] target;
  logic [RW-1:0]    count;
  logic             dropped;
  logic [CW-1:0]    tcol;
  logic [RW-1:0]    fi;
  logic [CW-1:0]    fj;
  logic [RW-1:0]    bi;
  logic [CW-1:0]    bj;
  logic [SUM_W-1:0] best;
  logic             first;

  // fill pipeline stage (read issued last cycle, write this cycle)
  logic             s_valid;
  logic [RW-1:0]    s_row;
  logic [CW-1:0]    s_col;
  logic             s_skip_only;
  logic             s_row1;
  logic [SUM_W-1:0] s_val;

  logic      out_valid;
  cssd_res_t out_res;

  // ---------------------------------------------------------------- datapath
  logic             in_fire;
  logic             store_full;
  logic [CW-1:0]    tsat;
  logic [RW-1:0]    fi_m1;
  logic [RW-1:0]    bi_m1;
  logic [RW-1:0]    sidx;
  logic [VALUE_W-1:0] sval;
  cssd_ins_t        ins;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign store_full = (count == RW'(MAX_ITEMS));
  assign tsat       = (17'(target) > 17'(MAX_TARGET)) ? CW'(MAX_TARGET) : CW'(target);
  assign fi_m1      = fi - RW'(1);
  assign bi_m1      = bi - RW'(1);
  assign sidx       = (state == ST_FILL) ? fi_m1 : bi_m1;

  assign ins.en    = in_fire && !store_full;
  assign ins.value = s_axis_tdata[VALUE_W-1:0];

  cssd_sort_store #(
    .DEPTH (MAX_ITEMS),
    .CNTW  (RW)
  ) u_store (
    .clk     (clk),
    .ins     (ins),
    .count   (count),
    .rd_idx  (sidx[IW-1:0]),
    .rd_data (sval)
  );

  // table RAM
  logic [AW-1:0]    raddr_a, raddr_b, waddr;
  logic [SUM_W-1:0] rd_a, rd_b, wdata;
  logic             fill_lt;
  logic [CW-1:0]    col_b;
  logic [SUM_W-1:0] skip;
  logic [SUM_W:0]   take;

  assign fill_lt = (VALUE_W'(fj) < sval);
  assign col_b   = fj - sval[CW-1:0];

  assign skip  = s_row1 ? '0 : rd_a;
  assign take  = {1'b0, (s_row1 ? SUM_W'(0) : rd_b)} + {1'b0, s_val};
  assign wdata = (s_skip_only || ({1'b0, skip} >= take)) ? skip : take[SUM_W-1:0];
  assign waddr = {s_row, s_col};

  cssd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (s_valid),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  // walk-back evaluation
  logic [SUM_W-1:0] cur, prv;
  logic             bt_empty, bt_take, bt_last, out_free;

  assign cur      = rd_a;
  assign prv      = (bi == RW'(1)) ? '0 : rd_b;
  assign bt_empty = first && (cur == '0);
  assign bt_take  = (cur != prv);
  assign bt_last  = (VALUE_W'(cur) == sval);
  assign out_free = !out_valid || m_axis_tready;

  // ------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_fire && s_axis_tlast) state_next = ST_FILL;
      ST_FILL:  if (fj == tcol) state_next = ST_GAP;
      ST_GAP:   state_next = (fi == count) ? ST_BT_RD : ST_FILL;
      ST_BT_RD: state_next = ST_BT_EV;
      ST_BT_EV: begin
        if (bt_empty) begin
          if (out_free) state_next = ST_LOAD;
        end else if (bt_take) begin
          if (out_free) state_next = bt_last ? ST_LOAD : ST_BT_RD;
        end else begin
          state_next = ST_BT_RD;
        end
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  logic      emit;
  logic      bt_step;
  logic      fill_issue;
  cssd_res_t emit_res;

  always_comb begin
    s_axis_tready = 1'b0;
    fill_issue    = 1'b0;
    emit          = 1'b0;
    bt_step       = 1'b0;
    raddr_a       = {bi, bj};
    raddr_b       = {bi_m1, bj};
    emit_res.element   = sval;
    emit_res.best_sum  = first ? cur : best;
    emit_res.empty_res = 1'b0;
    emit_res.overflow  = dropped;
    emit_res.final_res = bt_last;
    case (state)
      ST_LOAD: s_axis_tready = 1'b1;
      ST_FILL: begin
        fill_issue = 1'b1;
        raddr_a    = {fi_m1, fj};
        raddr_b    = {fi_m1, col_b};
      end
      ST_BT_EV: begin
        if (bt_empty) begin
          emit               = out_free;
          emit_res.element   = '0;
          emit_res.best_sum  = '0;
          emit_res.empty_res = 1'b1;
          emit_res.final_res = 1'b1;
        end else if (bt_take) begin
          emit    = out_free;
          bt_step = out_free;
        end else begin
          bt_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      target    <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      first     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) target <= cfg_wdata;

      if (ins.en) count <= count + RW'(1);
      if (in_fire && store_full) dropped <= 1'b1;
      if (emit && emit_res.final_res) begin
        count   <= '0;
        dropped <= 1'b0;
      end

      s_valid <= fill_issue;

      if (emit) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      if (state == ST_GAP) first <= 1'b1;
      else if (bt_step) first <= 1'b0;
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (in_fire && s_axis_tlast) begin
      tcol <= tsat;
      fi   <= RW'(1);
      fj   <= '0;
    end
    if (fill_issue) begin
      fj <= (fj == tcol) ? '0 : fj + CW'(1);
    end
    if (state == ST_GAP) begin
      fi <= fi + RW'(1);
      bi <= count;
      bj <= tcol;
    end
    s_row       <= fi;
    s_col       <= fj;
    s_skip_only <= fill_lt;
    s_row1      <= (fi == RW'(1));
    s_val       <= sval[SUM_W-1:0];
    if (first && state == ST_BT_EV) best <= cur;
    if (bt_step) begin
      bi <= bi_m1;
      if (bt_take) bj <= bj - sval[CW-1:0];
    end
    if (emit) out_res <= emit_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {OUT_PAD'(0), out_res.best_sum, out_res.element};
  assign m_axis_tuser  = {out_res.overflow, out_res.empty_res};
  assign m_axis_tlast  = out_res.final_res;

  // ------------------------------------------------------------- assertions
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || m_axis_tready))
    else $error("result written over an untaken transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  a_row_hazard: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && s_valid) |-> (s_row != fi_m1))
    else $error("table row read while still being written");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_res.final_res) |=> (count == '0 && !dropped && state == ST_LOAD))
    else $error("run state not cleared after final result");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_BT_EV) |-> !in_fire)
    else $error("value accepted during computation");

endmodule
`default_nettype wire

### design/cssd_ram.sv
`default_nettype none
// Generic RAM: one write port, two registered read ports.
module cssd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### design/cssd_sort_store.sv
`default_nettype none
// Row of cells holding values in ascending order; one insert per cycle.
module cssd_sort_store
  import cssd_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int CNTW  = 6
) (
  input  wire logic                     clk,
  input  wire cssd_ins_t                ins,
  input  wire logic [CNTW-1:0]          count,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx,
  output logic      [VALUE_W-1:0]       rd_data
);

  logic [VALUE_W-1:0] cells [DEPTH];
  logic [VALUE_W-1:0] prev  [DEPTH];
  logic [DEPTH-1:0]   gt;
  logic [DEPTH-1:0]   gt_prev;

  // gt: this cell moves up (holds a larger value, or is the free slot)
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = ((CNTW'(k) < count) && (cells[k] > ins.value)) || (CNTW'(k) == count);
    end
    prev[0]    = ins.value;
    gt_prev[0] = 1'b0;
    for (int k = 1; k < DEPTH; k++) begin
      prev[k]    = cells[k-1];
      gt_prev[k] = gt[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DEPTH; k++) begin
      if (ins.en && gt[k]) begin
        cells[k] <= gt_prev[k] ? prev[k] : ins.value;
      end
    end
  end

  assign rd_data = cells[rd_idx];

endmodule
`default_nettype wire
